@@ hw/rtl/fit_policy_block_allocator_unit_defines.svh @@
// assertion macros of the fit policy block allocator rtl
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// clocked check, off while reset is asserted
`define FPBA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// clocked check that also holds during reset
`define FPBA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define FPBA_ASSERT(name, prop, msg)
`define FPBA_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

@@ hw/rtl/fpba_pkg.sv @@
// types, constants and helper functions of the fit policy block allocator
package fpba_pkg;

  localparam int NUM_BLOCKS      = 16;
  localparam int SIZE_BITS       = 16;
  localparam int AMOUNT_BITS     = 16;
  localparam int IN_INDEX_BITS   = 4;
  localparam int OUT_INDEX_BITS  = 4;
  localparam int LEFT_OVER_BITS  = 16;
  localparam int COUNT_BITS      = 5;
  localparam int POLICY_BITS     = 2;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 5;

  // internal widths, wide enough for every field that meets them
  localparam int CLOG_BLOCKS = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int IDX_W       = (CLOG_BLOCKS > IN_INDEX_BITS) ? CLOG_BLOCKS : IN_INDEX_BITS;
  localparam int CMP_BITS    = (SIZE_BITS > AMOUNT_BITS) ? SIZE_BITS : AMOUNT_BITS;
  localparam int CLOG_USE    = $clog2(NUM_BLOCKS + 1);
  localparam int USE_W       = (CLOG_USE > COUNT_BITS) ? CLOG_USE : COUNT_BITS;

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_ALLOC = 1'b1
  } op_e;

  typedef enum logic [POLICY_BITS-1:0] {
    POLICY_FIRST = 2'd0,
    POLICY_BEST  = 2'd1,
    POLICY_WORST = 2'd2
  } policy_e;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_FIT_POLICY  = 2'd0,
    CFG_BLOCK_COUNT = 2'd1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

  typedef struct packed {
    logic                     operation;
    logic [IN_INDEX_BITS-1:0] block_index;
    logic [AMOUNT_BITS-1:0]   amount;
    logic                     last_request;
  } in_t;

  typedef struct packed {
    logic                      granted;
    logic [OUT_INDEX_BITS-1:0] chosen_block;
    logic [LEFT_OVER_BITS-1:0] left_over;
    logic                      last_of_batch;
  } out_t;

  // running pick handed from cell to cell
  typedef struct packed {
    logic                 found;
    logic [IDX_W-1:0]     idx;
    logic [SIZE_BITS-1:0] size;
  } token_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic                   load;
    logic                   update;
    logic [POLICY_BITS-1:0] policy;
    logic [IDX_W-1:0]       idx;
    logic [AMOUNT_BITS-1:0] amount;
  } cell_cmd_t;

  function automatic logic fits(logic [SIZE_BITS-1:0] size, logic [AMOUNT_BITS-1:0] req);
    return CMP_BITS'(size) >= CMP_BITS'(req);
  endfunction

  function automatic logic [SIZE_BITS-1:0] size_sub(logic [SIZE_BITS-1:0]   size,
                                                    logic [AMOUNT_BITS-1:0] req);
    logic [CMP_BITS-1:0] diff;
    diff = CMP_BITS'(size) - CMP_BITS'(req);
    return diff[SIZE_BITS-1:0];
  endfunction

  function automatic logic [SIZE_BITS-1:0] load_size(logic [AMOUNT_BITS-1:0] amount);
    logic [CMP_BITS-1:0] wide;
    wide = CMP_BITS'(amount);
    return wide[SIZE_BITS-1:0];
  endfunction

  function automatic logic [LEFT_OVER_BITS-1:0] report_size(logic [SIZE_BITS-1:0] size);
    logic [CMP_BITS-1:0] wide;
    wide = CMP_BITS'(size);
    return wide[LEFT_OVER_BITS-1:0];
  endfunction

endpackage

@@ hw/rtl/fpba_cell.sv @@
// one table entry of the allocator chain: holds a block size and refines the passing pick
module fpba_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  fpba_pkg::cell_cmd_t            cmd_i,
  input  logic [fpba_pkg::IDX_W-1:0]     cell_index_i,
  input  logic                           in_use_i,
  input  logic                           tok_valid_i,
  input  fpba_pkg::token_t               tok_i,
  output logic                           tok_valid_o,
  output fpba_pkg::token_t               tok_o
);

  logic [fpba_pkg::SIZE_BITS-1:0] size_q;
  logic                           tok_valid_q;
  fpba_pkg::token_t               tok_q, tok_d;
  logic                           hit;
  logic                           take;
  logic                           is_best;
  logic                           is_worst;

  assign hit      = (cmd_i.idx == cell_index_i);
  assign is_best  = (cmd_i.policy == fpba_pkg::POLICY_BEST);
  assign is_worst = (cmd_i.policy == fpba_pkg::POLICY_WORST);

  always_comb begin
    take = tok_valid_i && in_use_i && fpba_pkg::fits(size_q, cmd_i.amount) &&
           (!tok_i.found ||
            (is_best && (size_q < tok_i.size)) ||
            (is_worst && (size_q > tok_i.size)));
    tok_d = tok_i;
    if (take) begin
      tok_d.found = 1'b1;
      tok_d.idx   = cell_index_i;
      tok_d.size  = size_q;
    end
  end

  // entry storage, undefined until loaded
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && hit) begin
      size_q <= fpba_pkg::load_size(cmd_i.amount);
    end else if (cmd_i.update && hit) begin
      size_q <= fpba_pkg::size_sub(size_q, cmd_i.amount);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign tok_valid_o = tok_valid_q;
  assign tok_o       = tok_q;

endmodule

@@ hw/rtl/fit_policy_block_allocator_unit.sv @@
// top level of the fit policy block allocator: sequencer, config registers and cell chain
//
// A load item (operation 0) writes one block size at the edge where it is accepted and
// produces no result; busy_o stays low, so the next item may follow in the next cycle.
// An allocate item (operation 1) sends a pick token down a chain of NUM_BLOCKS cells, one
// cell per clock, each cell holding one block size and replacing the token's pick when its
// block fits better under the configured policy. busy_o rises with the scan state, registered
// at the accepting edge, and stays high while the token walks through the chain. When the
// token leaves the last cell the chosen block is reduced
// and the result is shown on result_o with result_valid_o high for exactly one cycle, the
// first cycle in which busy_o is low again. The receiver cannot stall: a result is taken at
// the edge that ends its cycle, so there is no backpressure path. Configuration writes are
// always ready and should only be issued while the block is idle. Block entries are
// undefined until loaded and must be loaded before an allocate covers them.
`include "fit_policy_block_allocator_unit_defines.svh"

module fit_policy_block_allocator_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // item command channel
  input  logic                                start_i,
  output logic                                busy_o,
  input  fpba_pkg::in_t                       in_i,
  // result strobe channel
  output logic                                result_valid_o,
  output fpba_pkg::out_t                      result_o,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fpba_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [fpba_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);

  localparam int NB = fpba_pkg::NUM_BLOCKS;

  // config registers
  logic [fpba_pkg::POLICY_BITS-1:0] fit_policy_q;
  logic [fpba_pkg::COUNT_BITS-1:0]  block_count_q;
  logic                             cfg_write;

  // sequencer
  fpba_pkg::state_e state_q, state_d;
  fpba_pkg::in_t    req_q;
  logic             inject_q, inject_d;
  logic             accept;
  logic             load_go;
  logic             alloc_go;
  logic             tail_valid;

  // result register
  logic           result_valid_q, result_valid_d;
  fpba_pkg::out_t result_q, result_d;

  // cell chain
  fpba_pkg::cell_cmd_t            cmd;
  logic [NB:0]                    tok_valid;
  fpba_pkg::token_t               tok [NB+1];
  logic [NB-1:0]                  in_use;
  logic [fpba_pkg::USE_W-1:0]     blocks_used;
  logic [fpba_pkg::USE_W-1:0]     count_wide;

  // config port is always ready, unknown indexes are dropped
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_policy_q  <= fpba_pkg::POLICY_FIRST;
      block_count_q <= '0;
    end else if (cfg_write) begin
      case (cfg_index_i)
        fpba_pkg::CFG_FIT_POLICY:  fit_policy_q  <= cfg_data_i[fpba_pkg::POLICY_BITS-1:0];
        fpba_pkg::CFG_BLOCK_COUNT: block_count_q <= cfg_data_i[fpba_pkg::COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // a block count above the table size covers the whole table
  assign count_wide  = fpba_pkg::USE_W'(block_count_q);
  assign blocks_used = (count_wide > fpba_pkg::USE_W'(NB)) ? fpba_pkg::USE_W'(NB) : count_wide;

  // handshake and next state
  assign accept     = start_i && !busy_o;
  assign load_go    = accept && (in_i.operation == fpba_pkg::OP_LOAD);
  assign alloc_go   = accept && (in_i.operation == fpba_pkg::OP_ALLOC);
  assign tail_valid = tok_valid[NB];

  always_comb begin
    state_d  = state_q;
    inject_d = 1'b0;
    busy_o   = 1'b0;
    case (state_q)
      fpba_pkg::ST_IDLE: begin
        if (alloc_go) begin
          state_d  = fpba_pkg::ST_SCAN;
          inject_d = 1'b1;
        end
      end
      fpba_pkg::ST_SCAN: begin
        busy_o = 1'b1;
        // token has passed every cell, result goes out this edge
        if (tail_valid) begin
          state_d = fpba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fpba_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fpba_pkg::ST_IDLE;
      inject_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      inject_q <= inject_d;
    end
  end

  // request held for the whole walk
  always_ff @(posedge clk_i) begin
    if (alloc_go) begin
      req_q <= in_i;
    end
  end

  // broadcast command: loads come from the port, scans use the held amount and tail index
  always_comb begin
    cmd.load   = load_go;
    cmd.update = tail_valid && tok[NB].found;
    cmd.policy = fit_policy_q;
    if (busy_o) begin
      cmd.idx    = tok[NB].idx;
      cmd.amount = req_q.amount;
    end else begin
      cmd.idx    = fpba_pkg::IDX_W'(in_i.block_index);
      cmd.amount = in_i.amount;
    end
  end

  // empty token enters the head of the chain
  assign tok_valid[0] = inject_q;
  always_comb begin
    tok[0]       = '0;
    tok[0].found = 1'b0;
  end

  for (genvar j = 0; j < NB; j++) begin : g_cell
    assign in_use[j] = (fpba_pkg::USE_W'(j) < blocks_used);

    fpba_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .cell_index_i (fpba_pkg::IDX_W'(j)),
      .in_use_i     (in_use[j]),
      .tok_valid_i  (tok_valid[j]),
      .tok_i        (tok[j]),
      .tok_valid_o  (tok_valid[j+1]),
      .tok_o        (tok[j+1])
    );
  end

  // result formatting at the tail, new size matches what the chosen cell stores
  always_comb begin
    result_valid_d         = tail_valid;
    result_d.granted       = tok[NB].found;
    result_d.chosen_block  = '0;
    result_d.left_over     = '0;
    result_d.last_of_batch = req_q.last_request;
    if (tok[NB].found) begin
      result_d.chosen_block = tok[NB].idx[fpba_pkg::OUT_INDEX_BITS-1:0];
      result_d.left_over    =
        fpba_pkg::report_size(fpba_pkg::size_sub(tok[NB].size, req_q.amount));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= result_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tail_valid) begin
      result_q <= result_d;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  // at most one token in flight
  `FPBA_ASSERT_ALWAYS(a_one_token, $onehot0(tok_valid), "more than one pick token in the chain")
  // an accepted allocate keeps the block busy for the walk
  `FPBA_ASSERT(a_alloc_busy, alloc_go |=> busy_o, "allocate accepted without going busy")
  // the strobe is a single cycle pulse
  `FPBA_ASSERT(a_strobe_pulse, result_valid_q |=> !result_valid_q, "result strobe held")
  // a refused request reports zero block and zero size
  `FPBA_ASSERT(a_refused_zero,
    (result_valid_q && !result_q.granted) |-> (result_q.chosen_block == '0 && result_q.left_over == '0),
    "refused request with nonzero fields")
  // the token only walks while scanning
  `FPBA_ASSERT(a_token_scan, (tok_valid != '0) |-> (state_q == fpba_pkg::ST_SCAN),
    "pick token outside a scan")

endmodule

@@ tb/testbench.sv @@
// self-checking testbench of the fit policy block allocator unit
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // policy code with no rule of its own, acts as first fit
  localparam logic [fpba_pkg::POLICY_BITS-1:0] POLICY_SPARE = 2'd3;
  // register indexes with no register behind them, writes there change nothing
  localparam logic [fpba_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [fpba_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_HI = 2'd3;
  localparam int unsigned ITEM_TARGET = 750;
  // slowest run: every item waits out a full scan plus the longest gap,
  // plus the settling pauses around every register phase
  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam int unsigned SETTLE_CYCLES = fpba_pkg::NUM_BLOCKS + 4;

  // tracks table contents and registers, predicts one result per allocate word
  class alloc_scoreboard;
    logic [fpba_pkg::SIZE_BITS-1:0]   size_tab [fpba_pkg::NUM_BLOCKS];
    logic [fpba_pkg::POLICY_BITS-1:0] fit_rule;
    logic [fpba_pkg::COUNT_BITS-1:0]  block_count;
    fpba_pkg::out_t                   grant_q [$];
    int unsigned                      fails;

    function new();
      foreach (size_tab[j]) size_tab[j] = '0;
      fit_rule    = fpba_pkg::POLICY_FIRST;
      block_count = '0;
      fails       = 0;
    endfunction

    function void note_reg(logic [fpba_pkg::CFG_INDEX_BITS-1:0] idx,
                           logic [fpba_pkg::CFG_DATA_BITS-1:0] data);
      case (idx)
        fpba_pkg::CFG_FIT_POLICY:  fit_rule = data[fpba_pkg::POLICY_BITS-1:0];
        fpba_pkg::CFG_BLOCK_COUNT: block_count = data[fpba_pkg::COUNT_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void note_word(fpba_pkg::in_t w);
      int unsigned    used;
      int unsigned    pick;
      bit             found;
      fpba_pkg::out_t r;
      if (w.operation == fpba_pkg::OP_LOAD) begin
        size_tab[w.block_index] = w.amount;
        return;
      end
      used  = (block_count > fpba_pkg::NUM_BLOCKS) ? fpba_pkg::NUM_BLOCKS : block_count;
      found = 1'b0;
      pick  = 0;
      for (int j = 0; j < used; j++) begin
        if (size_tab[j] < w.amount) continue;
        if (!found) begin
          found = 1'b1;
          pick  = j;
          // first fit and the spare code stop at the lowest fitting entry
          if (fit_rule != fpba_pkg::POLICY_BEST && fit_rule != fpba_pkg::POLICY_WORST) break;
        end else if (fit_rule == fpba_pkg::POLICY_BEST && size_tab[j] < size_tab[pick]) begin
          pick = j;
        end else if (fit_rule == fpba_pkg::POLICY_WORST && size_tab[j] > size_tab[pick]) begin
          pick = j;
        end
      end
      r = '0;
      r.last_of_batch = w.last_request;
      if (found) begin
        size_tab[pick]  = size_tab[pick] - w.amount;
        r.granted       = 1'b1;
        r.chosen_block  = fpba_pkg::OUT_INDEX_BITS'(pick);
        r.left_over     = size_tab[pick];
      end
      grant_q.push_back(r);
    endfunction

    function void check_word(fpba_pkg::out_t got);
      fpba_pkg::out_t want;
      if (grant_q.size() == 0) begin
        $error("result word with no allocate pending: %p", got);
        fails++;
        return;
      end
      want = grant_q.pop_front();
      if (got.granted !== want.granted) begin
        $error("granted: expected %0d, got %0d", want.granted, got.granted);
        fails++;
      end
      if (got.chosen_block !== want.chosen_block) begin
        $error("chosen_block: expected %0d, got %0d", want.chosen_block, got.chosen_block);
        fails++;
      end
      if (got.left_over !== want.left_over) begin
        $error("left_over: expected %0d, got %0d", want.left_over, got.left_over);
        fails++;
      end
      if (got.last_of_batch !== want.last_of_batch) begin
        $error("last_of_batch: expected %0d, got %0d", want.last_of_batch,
               got.last_of_batch);
        fails++;
      end
    endfunction

    function int unsigned pending();
      return grant_q.size();
    endfunction
  endclass

  logic                                clk_i;
  logic                                rst_ni      = 1'b0;
  logic                                start_i     = 1'b0;
  logic                                busy_o;
  fpba_pkg::in_t                       in_i        = '0;
  logic                                result_valid_o;
  fpba_pkg::out_t                      result_o;
  logic                                cfg_valid_i = 1'b0;
  logic                                cfg_ready_o;
  logic [fpba_pkg::CFG_INDEX_BITS-1:0] cfg_index_i = '0;
  logic [fpba_pkg::CFG_DATA_BITS-1:0]  cfg_data_i  = '0;

  alloc_scoreboard                  sb = new();
  // entries written at least once, an allocate never covers one outside this set
  logic [fpba_pkg::NUM_BLOCKS-1:0]  loaded_mask = '0;
  int unsigned                      blocks_used = 0;
  int unsigned                      items_sent  = 0;
  int unsigned                      cycle_count = 0;

  fit_policy_block_allocator_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .in_i           (in_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // watchdog: a hung block or a lost result ends the run here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result strobe lasts one cycle and cannot be held off, so check every edge
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_word(result_o);
  end

  function automatic fpba_pkg::in_t word_of(logic op, int unsigned idx, int unsigned amt,
                                            bit last);
    fpba_pkg::in_t w;
    w.operation    = op;
    w.block_index  = fpba_pkg::IN_INDEX_BITS'(idx);
    w.amount       = fpba_pkg::AMOUNT_BITS'(amt);
    w.last_request = last;
    return w;
  endfunction

  // hold start with the word until an edge sees busy low; busy_o only moves at
  // rising edges, so its value at the falling edge is what the next edge sees
  task automatic drive_item(fpba_pkg::in_t w);
    logic took;
    start_i <= 1'b1;
    in_i    <= w;
    forever begin
      @(negedge clk_i);
      took = !busy_o;
      @(posedge clk_i);
      if (took) break;
    end
    sb.note_word(w);
    if (w.operation == fpba_pkg::OP_LOAD) loaded_mask[w.block_index] = 1'b1;
    items_sent++;
  endtask

  task automatic idle_gap(int unsigned n);
    if (n == 0) return;
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // leaves valid high; the caller lowers it after its last write
  task automatic write_reg(logic [fpba_pkg::CFG_INDEX_BITS-1:0] idx,
                           logic [fpba_pkg::CFG_DATA_BITS-1:0] data);
    logic took;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    forever begin
      @(negedge clk_i);
      took = cfg_ready_o;
      @(posedge clk_i);
      if (took) break;
    end
    sb.note_reg(idx, data);
  endtask

  // register writes only once every allocate has reported and the scan is over
  task automatic set_regs(logic [fpba_pkg::CFG_DATA_BITS-1:0] policy_data,
                          logic [fpba_pkg::CFG_DATA_BITS-1:0] count_data, bit spare_write);
    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if ($urandom_range(0, 1) == 0) begin
      write_reg(fpba_pkg::CFG_FIT_POLICY, policy_data);
      write_reg(fpba_pkg::CFG_BLOCK_COUNT, count_data);
    end else begin
      write_reg(fpba_pkg::CFG_BLOCK_COUNT, count_data);
      write_reg(fpba_pkg::CFG_FIT_POLICY, policy_data);
    end
    if (spare_write)
      write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                fpba_pkg::CFG_DATA_BITS'($urandom));
    cfg_valid_i <= 1'b0;
    blocks_used = (count_data > fpba_pkg::NUM_BLOCKS) ? fpba_pkg::NUM_BLOCKS : count_data;
  endtask

  // mostly short gaps, now and then one longer than a whole scan
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic int unsigned pick_load_size();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 2000);
    if (r < 8) return ($urandom_range(0, 1) ? 100 : 200);  // repeated sizes force ties
    if (r < 9) return $urandom_range(0, 65535);
    return ($urandom_range(0, 1) ? 0 : 65535);
  endfunction

  function automatic int unsigned pick_request();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(0, 600);
    // exact fit against a live entry, can leave zero behind
    if (r < 6 && blocks_used > 0) return 32'(sb.size_tab[$urandom_range(0, blocks_used - 1)]);
    if (r < 7) return 0;
    if (r < 8) return 65535;
    return $urandom_range(0, 65535);
  endfunction

  task automatic random_phase(int unsigned n_items, bit no_idle);
    fpba_pkg::in_t w;
    for (int unsigned i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 3) == 0)
        w = word_of(fpba_pkg::OP_LOAD, $urandom_range(0, fpba_pkg::NUM_BLOCKS - 1),
                    pick_load_size(), 1'($urandom_range(0, 1)));
      else
        w = word_of(fpba_pkg::OP_ALLOC, $urandom_range(0, fpba_pkg::NUM_BLOCKS - 1),
                    pick_request(), 1'($urandom_range(0, 1)));
      drive_item(w);
      if (!no_idle) idle_gap(pick_gap());
    end
  endtask

  initial begin
    logic [fpba_pkg::CFG_DATA_BITS-1:0] count_data;
    logic [fpba_pkg::CFG_DATA_BITS-1:0] policy_data;
    int unsigned                        r;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part ---
    // nothing in use right after reset: never granted
    drive_item(word_of(fpba_pkg::OP_ALLOC, 0, 0, 1'b1));

    set_regs(fpba_pkg::CFG_DATA_BITS'(fpba_pkg::POLICY_FIRST), 5'd4, 1'b0);
    drive_item(word_of(fpba_pkg::OP_LOAD, 0, 100, 1'b0));
    drive_item(word_of(fpba_pkg::OP_LOAD, 1, 65535, 1'b0));
    drive_item(word_of(fpba_pkg::OP_LOAD, 2, 0, 1'b0));
    drive_item(word_of(fpba_pkg::OP_LOAD, 3, 300, 1'b1));     // last flag on a load is ignored
    drive_item(word_of(fpba_pkg::OP_LOAD, 15, 65535, 1'b0));  // above the count, joins later
    drive_item(word_of(fpba_pkg::OP_ALLOC, 0, 50, 1'b0));
    drive_item(word_of(fpba_pkg::OP_ALLOC, 0, 65535, 1'b1));  // whole largest block
    drive_item(word_of(fpba_pkg::OP_ALLOC, 0, 0, 1'b0));
    drive_item(word_of(fpba_pkg::OP_ALLOC, 0, 400, 1'b1));    // larger than every entry

    set_regs(fpba_pkg::CFG_DATA_BITS'(fpba_pkg::POLICY_BEST), 5'd4, 1'b0);
    drive_item(word_of(fpba_pkg::OP_ALLOC, 0, 40, 1'b0));
    drive_item(word_of(fpba_pkg::OP_ALLOC, 0, 0, 1'b1));      // zero sizes tie, lowest wins

    set_regs(fpba_pkg::CFG_DATA_BITS'(fpba_pkg::POLICY_WORST), 5'd4, 1'b0);
    drive_item(word_of(fpba_pkg::OP_ALLOC, 0, 10, 1'b0));
    drive_item(word_of(fpba_pkg::OP_ALLOC, 0, 65535, 1'b1));

    set_regs(fpba_pkg::CFG_DATA_BITS'(POLICY_SPARE), 5'd2, 1'b1);
    drive_item(word_of(fpba_pkg::OP_ALLOC, 0, 5, 1'b0));

    set_regs(fpba_pkg::CFG_DATA_BITS'(fpba_pkg::POLICY_BEST), 5'd4, 1'b0);
    drive_item(word_of(fpba_pkg::OP_LOAD, 2, 7, 1'b0));
    drive_item(word_of(fpba_pkg::OP_LOAD, 3, 7, 1'b0));
    drive_item(word_of(fpba_pkg::OP_ALLOC, 0, 7, 1'b1));      // equal best sizes, lowest wins

    // --- random part: one register setting per phase ---
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 9);
      case (r)
        0:       count_data = 5'd0;
        1:       count_data = 5'd1;
        2:       count_data = 5'd16;
        3:       count_data = 5'd17;
        4:       count_data = 5'd31;
        default: count_data = fpba_pkg::CFG_DATA_BITS'($urandom_range(2, fpba_pkg::NUM_BLOCKS));
      endcase
      policy_data = {3'($urandom_range(0, 7)),
                     ($urandom_range(0, 7) == 0) ? POLICY_SPARE
                                                 : fpba_pkg::POLICY_BITS'($urandom_range(0, 2))};
      set_regs(policy_data, count_data, $urandom_range(0, 4) == 0);
      // every entry an allocate may read must hold a loaded size
      for (int unsigned j = 0; j < blocks_used; j++) begin
        if (!loaded_mask[j]) begin
          drive_item(word_of(fpba_pkg::OP_LOAD, j, pick_load_size(),
                             1'($urandom_range(0, 1))));
          idle_gap(pick_gap());
        end
      end
      random_phase($urandom_range(20, 70), $urandom_range(0, 3) == 0);
    end

    // drain: every allocate reports, then a full scan's worth of quiet
    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.fails == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/fpba_pkg.sv
hw/rtl/fpba_cell.sv
hw/rtl/fit_policy_block_allocator_unit.sv
tb/testbench.sv
